// File: sv/mccs_pkg.sv
// shared types, controller numbers and normalisation helpers for the channel controller state
`default_nettype none

package mccs_pkg;

  localparam int unsigned NUM_CONTROLLERS = 128;
  localparam int unsigned CTRL_W          = 7;
  localparam int unsigned Q16_W           = 17;

  // request codes
  typedef enum logic [1:0] {
    REQ_CC    = 2'd0,
    REQ_PC    = 2'd1,
    REQ_PB    = 2'd2,
    REQ_QUERY = 2'd3
  } req_t;

  // sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_EVAL,
    S_MUL,
    S_MULW,
    S_OUT
  } state_t;

  // controller numbers with a meaning of their own
  localparam logic [6:0] CC_BANK_MSB    = 7'd0;
  localparam logic [6:0] CC_DATA_MSB    = 7'd6;
  localparam logic [6:0] CC_VOLUME      = 7'd7;
  localparam logic [6:0] CC_EXPRESSION  = 7'd11;
  localparam logic [6:0] CC_BANK_LSB    = 7'd32;
  localparam logic [6:0] CC_DATA_LSB    = 7'd38;
  localparam logic [6:0] CC_VOLUME_LSB  = 7'd39;
  localparam logic [6:0] CC_EXPR_LSB    = 7'd43;
  localparam logic [6:0] CC_RPN_LSB     = 7'd100;
  localparam logic [6:0] CC_RPN_MSB     = 7'd101;

  // registered parameter numbers
  localparam logic [6:0] RPN_BEND_RANGE = 7'd0;
  localparam logic [6:0] RPN_FINE_TUNE  = 7'd1;
  localparam logic [6:0] RPN_COARSE     = 7'd2;

  // unity level in Q1.16
  localparam logic [16:0] Q_ONE = 17'h10000;

  // lsb controllers 32..63 fold onto their msb partner
  function automatic logic [6:0] pair_msb(input logic [6:0] c);
    if (c[6:5] == 2'b01) begin
      return {2'b00, c[4:0]};
    end
    return c;
  endfunction

  // q1.16 value: combined pair times 4, else floor(v * 65536 / 127)
  // 65536 = 127 * 516 + 4, so the remainder term floor(4v / 127) is 0..4
  function automatic logic [16:0] norm_q16(input logic [6:0] msb, input logic [6:0] lsb,
                                           input logic paired);
    logic [2:0]  corr;
    logic [16:0] base;
    corr = 3'(msb >= 7'd32) + 3'(msb >= 7'd64) + 3'(msb >= 7'd96) + 3'(msb == 7'd127);
    base = {1'b0, msb, 9'b0} + {8'b0, msb, 2'b0};
    if (paired && (lsb != 7'd0)) begin
      return {1'b0, msb, lsb, 2'b00};
    end
    return base + {14'b0, corr};
  endfunction

  // side reads that each request type needs, four slots
  function automatic logic [6:0] aux_addr(input req_t req, input logic [1:0] slot);
    logic [6:0] a;
    a = CC_RPN_MSB;
    unique case (req)
      REQ_PC: begin
        a = slot[0] ? CC_BANK_LSB : CC_BANK_MSB;
      end
      REQ_QUERY: begin
        unique case (slot)
          2'd0: a = CC_VOLUME;
          2'd1: a = CC_VOLUME_LSB;
          2'd2: a = CC_EXPRESSION;
          default: a = CC_EXPR_LSB;
        endcase
      end
      default: begin
        unique case (slot)
          2'd0: a = CC_RPN_MSB;
          2'd1: a = CC_RPN_LSB;
          2'd2: a = CC_DATA_MSB;
          default: a = CC_DATA_LSB;
        endcase
      end
    endcase
    return a;
  endfunction

endpackage

`default_nettype wire

// File: sv/midi_channel_controller_state_top.sv
// controller state of one midi channel: sequenced memory reads and a shared multiplier
// requests are handled one at a time: busy stays high from the transfer until the done strobe,
// so a new request is taken only after the previous result
// each request makes six reads through the single controller memory port;
// the level cube for a volume or expression query takes three passes through the one 17x17 multiplier
// reset: synchronous, clears all control state and the per-entry valid and used bits at once
`default_nettype none

module midi_channel_controller_state_top
  import mccs_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  req_type,
  input  wire logic [6:0]  controller,
  input  wire logic [13:0] data_value,
  output logic             done,
  output logic [16:0]      computed_value,
  output logic [6:0]       raw_value,
  output logic [13:0]      combined_value,
  output logic [13:0]      bend_range,
  output logic [13:0]      fine_tuning,
  output logic [13:0]      coarse_tuning,
  output logic [6:0]       bank_high,
  output logic [6:0]       bank_low,
  output logic [6:0]       program_number,
  output logic [13:0]      bend_amount,
  output logic             first_use,
  output logic [2:0]       presets_used
);

  state_t state, state_next;

  // request latched at the transfer
  logic       accept;
  req_t       req_in;
  req_t       req_q;
  logic [6:0] c_q;
  logic [6:0] m_in;
  logic [6:0] m_q;

  // controller memory with reset valid bits
  logic [6:0] store_mem [NUM_CONTROLLERS];
  logic [NUM_CONTROLLERS-1:0] store_vld;
  logic [NUM_CONTROLLERS-1:0] used;
  logic [6:0] raddr;
  logic [6:0] mem_q;
  logic       vld_q;
  logic [6:0] rd_eff;

  // read sequencing
  logic [2:0] rd_cnt;
  logic [2:0] rd_slot;
  logic [6:0] rd_val [6];

  // channel state
  logic [1:0]  level_written;
  logic [13:0] range_reg;
  logic [13:0] fine_reg;
  logic [13:0] coarse_reg;
  logic [13:0] bank_regs;
  logic [6:0]  program_reg;
  logic [13:0] bend_reg;
  logic [2:0]  preset_flags;

  // evaluation terms
  logic        paired;
  logic        is_cube;
  logic [16:0] norm_val;
  logic [16:0] vol_val;
  logic [16:0] expr_val;
  logic [13:0] entry_val;
  logic        entry_hit;

  // shared multiplier
  logic [16:0] op_x;
  logic [16:0] op_y;
  logic [32:0] prod;
  logic [16:0] prod_hi;
  logic [16:0] p_r;
  logic [1:0]  mstep;

  assign req_in = req_t'(req_type);
  assign accept = start && !busy;
  assign m_in   = pair_msb(controller);

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and handshake outputs
  always_comb begin
    state_next = state;
    busy       = 1'b1;
    done       = 1'b0;
    unique case (state)
      S_IDLE: begin
        busy = 1'b0;
        if (start) begin
          state_next = S_READ;
        end
      end
      S_READ: begin
        if (rd_cnt == 3'd6) begin
          state_next = S_EVAL;
        end
      end
      S_EVAL: begin
        state_next = is_cube ? S_MUL : S_OUT;
      end
      S_MUL: begin
        state_next = S_MULW;
      end
      S_MULW: begin
        state_next = (mstep == 2'd2) ? S_OUT : S_MUL;
      end
      S_OUT: begin
        done       = 1'b1;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // request capture
  always_ff @(posedge clk) begin
    if (accept) begin
      req_q <= req_in;
      c_q   <= controller;
      m_q   <= m_in;
    end
  end

  // read counter
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_cnt <= 3'd0;
    end else if (state == S_READ) begin
      rd_cnt <= (rd_cnt == 3'd6) ? 3'd0 : rd_cnt + 3'd1;
    end else begin
      rd_cnt <= 3'd0;
    end
  end

  // read address: msb, lsb partner, then four side reads
  always_comb begin
    if (rd_cnt == 3'd0) begin
      raddr = m_q;
    end else if (rd_cnt == 3'd1) begin
      raddr = 7'(m_q + 7'd32);
    end else begin
      raddr = aux_addr(req_q, 2'(rd_cnt - 3'd2));
    end
  end

  // controller memory, written at the transfer
  always_ff @(posedge clk) begin
    if (accept && (req_in == REQ_CC)) begin
      store_mem[controller] <= data_value[6:0];
    end
    mem_q <= store_mem[raddr];
  end

  // valid and used bits; a write to an msb clears its lsb partner
  always_ff @(posedge clk) begin
    if (rst) begin
      store_vld <= '0;
      used      <= '0;
      vld_q     <= 1'b0;
    end else begin
      vld_q <= store_vld[raddr];
      if (accept && (req_in == REQ_CC)) begin
        store_vld[controller] <= 1'b1;
        used[m_in]            <= 1'b1;
        if (controller[6:5] == 2'b00) begin
          store_vld[{2'b01, controller[4:0]}] <= 1'b0;
        end
      end
    end
  end

  assign rd_eff  = vld_q ? mem_q : 7'd0;
  assign rd_slot = rd_cnt - 3'd1;

  // read data capture, one slot a cycle
  always_ff @(posedge clk) begin
    if ((state == S_READ) && (rd_cnt != 3'd0)) begin
      rd_val[rd_slot] <= rd_eff;
    end
  end

  // evaluation terms from the captured reads
  assign paired    = (m_q[6:5] == 2'b00);
  assign norm_val  = norm_q16(rd_val[0], rd_val[1], paired);
  assign vol_val   = level_written[0] ? norm_q16(rd_val[2], rd_val[3], 1'b1) : Q_ONE;
  assign expr_val  = level_written[1] ? norm_q16(rd_val[4], rd_val[5], 1'b1) : Q_ONE;
  assign is_cube   = (req_q == REQ_QUERY) && ((c_q == CC_VOLUME) || (c_q == CC_EXPRESSION));
  assign entry_hit = (req_q == REQ_CC) && ((c_q == CC_DATA_MSB) || (c_q == CC_DATA_LSB))
                     && (rd_val[2] == 7'd0);
  assign entry_val = (rd_val[5] != 7'd0) ? {rd_val[4], rd_val[5]} : {7'd0, rd_val[4]};

  // channel state updates
  always_ff @(posedge clk) begin
    if (rst) begin
      level_written <= 2'b00;
      range_reg     <= '0;
      fine_reg      <= '0;
      coarse_reg    <= '0;
      bank_regs     <= '0;
      program_reg   <= '0;
      bend_reg      <= '0;
      preset_flags  <= '0;
      first_use     <= 1'b0;
    end else begin
      if (accept) begin
        first_use <= (req_in == REQ_CC) && !used[m_in];
        unique case (req_in)
          REQ_CC: begin
            if (m_in == CC_VOLUME) begin
              level_written[0] <= 1'b1;
            end
            if (m_in == CC_EXPRESSION) begin
              level_written[1] <= 1'b1;
            end
          end
          REQ_PC: begin
            program_reg <= data_value[6:0];
          end
          REQ_PB: begin
            bend_reg        <= data_value;
            preset_flags[0] <= 1'b1;
          end
          default: begin
          end
        endcase
      end
      if (state == S_EVAL) begin
        if (req_q == REQ_PC) begin
          bank_regs <= {rd_val[2], rd_val[3]};
        end
        // data entry under rpn 0/0, 0/1 or 0/2
        if (entry_hit) begin
          if (rd_val[3] == RPN_BEND_RANGE) begin
            range_reg <= entry_val;
          end else if (rd_val[3] == RPN_FINE_TUNE) begin
            fine_reg        <= entry_val;
            preset_flags[1] <= 1'b1;
          end else if (rd_val[3] == RPN_COARSE) begin
            coarse_reg      <= entry_val;
            preset_flags[2] <= 1'b1;
          end
        end
      end
    end
  end

  // result registers for the addressed controller
  always_ff @(posedge clk) begin
    if (state == S_EVAL) begin
      raw_value      <= (c_q[6:5] == 2'b01) ? rd_val[1] : rd_val[0];
      combined_value <= (paired && (rd_val[1] != 7'd0)) ? {rd_val[0], rd_val[1]}
                                                          : {7'd0, rd_val[0]};
      computed_value <= (req_q == REQ_QUERY) ? norm_val : 17'd0;
    end else if ((state == S_MULW) && (mstep == 2'd2)) begin
      computed_value <= prod_hi;
    end
  end

  assign prod_hi = prod[32:16];

  // level cube: p = vol*expr, then p*p, then p2*p, each taken >> 16
  always_ff @(posedge clk) begin
    if (rst) begin
      mstep <= 2'd0;
    end else if (state == S_EVAL) begin
      mstep <= 2'd0;
    end else if (state == S_MULW) begin
      mstep <= mstep + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_EVAL) begin
      op_x <= vol_val;
      op_y <= expr_val;
    end else if (state == S_MUL) begin
      prod <= 33'(op_x * op_y);
    end else if (state == S_MULW) begin
      if (mstep == 2'd0) begin
        op_x <= prod_hi;
        op_y <= prod_hi;
        p_r  <= prod_hi;
      end else begin
        op_x <= prod_hi;
        op_y <= p_r;
      end
    end
  end

  // state registers straight to the result ports
  assign bend_range     = range_reg;
  assign fine_tuning    = fine_reg;
  assign coarse_tuning  = coarse_reg;
  assign bank_high      = bank_regs[13:7];
  assign bank_low       = bank_regs[6:0];
  assign program_number = program_reg;
  assign bend_amount    = bend_reg;
  assign presets_used   = preset_flags;

endmodule

`default_nettype wire

// File: sv/mccs_checker.sv
// port-level checks on the controller state block and their binding
`default_nettype none

module mccs_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       start,
  input wire logic       busy,
  input wire logic       done,
  input wire logic [2:0] presets_used
);

  // a transfer always starts work
  assert property (@(posedge clk) disable iff (rst) (start && !busy) |=> busy)
    else $error("no work after a start transfer");

  // a result never appears while idle
  assert property (@(posedge clk) disable iff (rst) done |-> busy)
    else $error("result strobe while idle");

  // the block frees up right after its result
  assert property (@(posedge clk) disable iff (rst) done |=> (!busy && !done))
    else $error("block still busy after its result");

  // preset flags only ever gain bits outside reset
  assert property (@(posedge clk) disable iff (rst)
                   !$past(rst) |-> ((presets_used & $past(presets_used)) == $past(presets_used)))
    else $error("preset flag cleared without reset");

endmodule

bind midi_channel_controller_state_top mccs_checker u_mccs_checker (
  .clk          (clk),
  .rst          (rst),
  .start        (start),
  .busy         (busy),
  .done         (done),
  .presets_used (presets_used)
);

`default_nettype wire

// File: test/tb.sv
// testbench for the midi channel controller state block: predicted results checked per transfer
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import mccs_pkg::*;

  // one result as seen on the output ports
  typedef struct {
    logic [16:0] computed;
    logic [6:0]  raw;
    logic [13:0] combined;
    logic [13:0] range;
    logic [13:0] fine;
    logic [13:0] coarse;
    logic [6:0]  bank_hi;
    logic [6:0]  bank_lo;
    logic [6:0]  prog;
    logic [13:0] bend;
    logic        first;
    logic [2:0]  presets;
  } chan_report_t;

  // channel state predictor and queue of reports still owed by the block
  class chan_state_scoreboard;
    logic [6:0]   ctrl_mem [NUM_CONTROLLERS];
    bit           used_bits [NUM_CONTROLLERS];
    logic [1:0]   level_seen;
    logic [13:0]  range_q;
    logic [13:0]  fine_q;
    logic [13:0]  coarse_q;
    logic [13:0]  bank_q;
    logic [6:0]   program_q;
    logic [13:0]  bend_q;
    logic [2:0]   preset_q;
    chan_report_t reports_q[$];
    int unsigned  errors;

    function new();
      foreach (ctrl_mem[i]) begin
        ctrl_mem[i]  = '0;
        used_bits[i] = 1'b0;
      end
      level_seen = '0;
      range_q    = '0;
      fine_q     = '0;
      coarse_q   = '0;
      bank_q     = '0;
      program_q  = '0;
      bend_q     = '0;
      preset_q   = '0;
      errors     = 0;
    endfunction

    // lsb controllers fold onto their msb partner
    function int fold_pair(int c);
      return (c >= 32 && c <= 63) ? c - 32 : c;
    endfunction

    function logic [13:0] pair_value(int c);
      int m;
      m = fold_pair(c);
      if (m > 31) begin
        return {7'd0, ctrl_mem[m]};
      end
      if (ctrl_mem[m + 32] != 7'd0) begin
        return {ctrl_mem[m], ctrl_mem[m + 32]};
      end
      return {7'd0, ctrl_mem[m]};
    endfunction

    // q1.16 normalisation of the addressed controller
    function longint unsigned q16_of(int c);
      int m;
      m = fold_pair(c);
      if (m <= 31 && ctrl_mem[m + 32] != 7'd0) begin
        return longint'(pair_value(m)) * 4;
      end
      return (longint'(ctrl_mem[m]) * 65536) / 127;
    endfunction

    function longint unsigned level_of(int c, int slot);
      if (!level_seen[slot]) begin
        return 65536;
      end
      return q16_of(c);
    endfunction

    // volume and expression return the cube of their product
    function logic [16:0] query_of(int c);
      longint unsigned p;
      longint unsigned p2;
      if (c == CC_VOLUME || c == CC_EXPRESSION) begin
        p  = (level_of(CC_VOLUME, 0) * level_of(CC_EXPRESSION, 1)) >> 16;
        p2 = (p * p) >> 16;
        return 17'((p2 * p) >> 16);
      end
      return 17'(q16_of(c));
    endfunction

    // apply one accepted request and queue the report it causes
    function void note_request(req_t kind, logic [6:0] ctrl, logic [13:0] data);
      chan_report_t rep;
      int           c;
      int           m;
      logic [13:0]  entry;
      c = ctrl;
      m = fold_pair(c);
      rep.computed = '0;
      rep.first    = 1'b0;
      case (kind)
        REQ_CC: begin
          ctrl_mem[c] = data[6:0];
          if (c <= 31) begin
            ctrl_mem[c + 32] = '0;
          end
          if (!used_bits[m]) begin
            used_bits[m] = 1'b1;
            rep.first    = 1'b1;
          end
          if (m == CC_VOLUME) begin
            level_seen[0] = 1'b1;
          end
          if (m == CC_EXPRESSION) begin
            level_seen[1] = 1'b1;
          end
          // data entry only counts under rpn msb 0
          if ((c == CC_DATA_MSB || c == CC_DATA_LSB) && ctrl_mem[CC_RPN_MSB] == 7'd0) begin
            entry = (c == CC_DATA_MSB) ? {7'd0, ctrl_mem[CC_DATA_MSB]} : pair_value(CC_DATA_MSB);
            case (ctrl_mem[CC_RPN_LSB])
              RPN_BEND_RANGE: begin
                range_q = entry;
              end
              RPN_FINE_TUNE: begin
                fine_q      = entry;
                preset_q[1] = 1'b1;
              end
              RPN_COARSE: begin
                coarse_q    = entry;
                preset_q[2] = 1'b1;
              end
              default: begin
              end
            endcase
          end
        end
        REQ_PC: begin
          bank_q    = {ctrl_mem[CC_BANK_MSB], ctrl_mem[CC_BANK_LSB]};
          program_q = data[6:0];
        end
        REQ_PB: begin
          bend_q      = data;
          preset_q[0] = 1'b1;
        end
        default: begin
          rep.computed = query_of(c);
        end
      endcase
      rep.raw      = ctrl_mem[c];
      rep.combined = pair_value(c);
      rep.range    = range_q;
      rep.fine     = fine_q;
      rep.coarse   = coarse_q;
      rep.bank_hi  = bank_q[13:7];
      rep.bank_lo  = bank_q[6:0];
      rep.prog     = program_q;
      rep.bend     = bend_q;
      rep.presets  = preset_q;
      reports_q.insert(reports_q.size(), rep);
    endfunction

    function void cmp_field(string name, logic [16:0] want, logic [16:0] got);
      if (got !== want) begin
        errors++;
        $error("%s: expected %0d, got %0d", name, want, got);
      end
    endfunction

    // compare one strobed result with the oldest report owed
    function void check_report(chan_report_t got);
      chan_report_t want;
      if (reports_q.size() == 0) begin
        errors++;
        $error("result strobed with no request outstanding");
        return;
      end
      want = reports_q.pop_front();
      cmp_field("computed_value", want.computed, got.computed);
      cmp_field("raw_value", want.raw, got.raw);
      cmp_field("combined_value", want.combined, got.combined);
      cmp_field("bend_range", want.range, got.range);
      cmp_field("fine_tuning", want.fine, got.fine);
      cmp_field("coarse_tuning", want.coarse, got.coarse);
      cmp_field("bank_high", want.bank_hi, got.bank_hi);
      cmp_field("bank_low", want.bank_lo, got.bank_lo);
      cmp_field("program_number", want.prog, got.prog);
      cmp_field("bend_amount", want.bend, got.bend);
      cmp_field("first_use", want.first, got.first);
      cmp_field("presets_used", want.presets, got.presets);
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  logic [1:0]  req_type;
  logic [6:0]  controller;
  logic [13:0] data_value;
  logic        done;
  logic [16:0] computed_value;
  logic [6:0]  raw_value;
  logic [13:0] combined_value;
  logic [13:0] bend_range;
  logic [13:0] fine_tuning;
  logic [13:0] coarse_tuning;
  logic [6:0]  bank_high;
  logic [6:0]  bank_low;
  logic [6:0]  program_number;
  logic [13:0] bend_amount;
  logic        first_use;
  logic [2:0]  presets_used;

  chan_state_scoreboard sb = new();
  int unsigned          items_sent;
  bit                   no_gaps;

  midi_channel_controller_state_top u_top (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .req_type       (req_type),
    .controller     (controller),
    .data_value     (data_value),
    .done           (done),
    .computed_value (computed_value),
    .raw_value      (raw_value),
    .combined_value (combined_value),
    .bend_range     (bend_range),
    .fine_tuning    (fine_tuning),
    .coarse_tuning  (coarse_tuning),
    .bank_high      (bank_high),
    .bank_low       (bank_low),
    .program_number (program_number),
    .bend_amount    (bend_amount),
    .first_use      (first_use),
    .presets_used   (presets_used)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // run limit
  initial begin
    #1_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  // result monitor: a strobed result is taken at the edge closing its cycle
  always @(posedge clk) begin
    chan_report_t got;
    if (!rst && done) begin
      got.computed = computed_value;
      got.raw      = raw_value;
      got.combined = combined_value;
      got.range    = bend_range;
      got.fine     = fine_tuning;
      got.coarse   = coarse_tuning;
      got.bank_hi  = bank_high;
      got.bank_lo  = bank_low;
      got.prog     = program_number;
      got.bend     = bend_amount;
      got.first    = first_use;
      got.presets  = presets_used;
      sb.check_report(got);
    end
  end

  // one request transfer, after a random idle gap when gaps are enabled
  task automatic issue(input req_t kind, input logic [6:0] ctrl, input logic [13:0] data);
    int unsigned gap;
    gap = no_gaps ? 0 : $urandom_range(0, 8);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start      <= 1'b1;
    req_type   <= kind;
    controller <= ctrl;
    data_value <= data;
    do begin
      @(posedge clk);
    end while (busy);
    sb.note_request(kind, ctrl, data);
    items_sent++;
  endtask

  // 7-bit value with junk in the upper data bits now and then
  function automatic logic [13:0] wide7(input logic [6:0] v);
    return {($urandom_range(0, 3) == 0) ? 7'($urandom) : 7'd0, v};
  endfunction

  // random traffic built mostly from well-formed midi sequences
  task automatic random_traffic();
    int unsigned pick;
    logic [6:0]  lvl;
    while (items_sent < 1150) begin
      if ($urandom_range(0, 9) == 0) begin
        no_gaps = !no_gaps;
      end
      pick = $urandom_range(0, 99);
      if (pick < 30) begin
        // rpn select then data entry
        issue(REQ_CC, CC_RPN_MSB, wide7(($urandom_range(0, 7) == 0) ? 7'($urandom) : 7'd0));
        issue(REQ_CC, CC_RPN_LSB,
              wide7(($urandom_range(0, 5) == 0) ? 7'($urandom) : 7'($urandom_range(0, 2))));
        issue(REQ_CC, CC_DATA_MSB, 14'($urandom));
        if ($urandom_range(0, 1) == 1) begin
          issue(REQ_CC, CC_DATA_LSB, 14'($urandom));
        end
        if ($urandom_range(0, 2) == 0) begin
          issue(REQ_QUERY, ($urandom_range(0, 1) == 1) ? CC_DATA_MSB : CC_DATA_LSB, 14'($urandom));
        end
      end else if (pick < 45) begin
        // bank select then program change
        issue(REQ_CC, CC_BANK_MSB, 14'($urandom));
        if ($urandom_range(0, 1) == 1) begin
          issue(REQ_CC, CC_BANK_LSB, 14'($urandom));
        end
        issue(REQ_PC, 7'($urandom), 14'($urandom));
      end else if (pick < 60) begin
        // level write then a level query
        case ($urandom_range(0, 3))
          0: lvl = CC_VOLUME;
          1: lvl = CC_VOLUME_LSB;
          2: lvl = CC_EXPRESSION;
          default: lvl = CC_EXPR_LSB;
        endcase
        case ($urandom_range(0, 3))
          0: issue(REQ_CC, lvl, wide7(7'd0));
          1: issue(REQ_CC, lvl, wide7(7'd127));
          default: issue(REQ_CC, lvl, 14'($urandom));
        endcase
        issue(REQ_QUERY, ($urandom_range(0, 1) == 1) ? CC_VOLUME : CC_EXPRESSION, 14'($urandom));
      end else if (pick < 72) begin
        issue(REQ_PB, 7'($urandom), 14'($urandom));
      end else if (pick < 87) begin
        issue(REQ_QUERY, 7'($urandom), 14'($urandom));
      end else begin
        issue(REQ_CC, 7'($urandom), 14'($urandom));
      end
    end
  endtask

  // stimulus and end of run
  initial begin
    start      <= 1'b0;
    rst        <= 1'b1;
    req_type   <= REQ_CC;
    controller <= '0;
    data_value <= '0;
    items_sent = 0;
    no_gaps    = 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // levels before any write read as unity
    issue(REQ_QUERY, CC_VOLUME, 14'h3FFF);
    issue(REQ_QUERY, CC_BANK_MSB, 14'd0);
    // wide data on a control change keeps only the low bits
    issue(REQ_CC, CC_VOLUME, 14'h3FFF);
    issue(REQ_QUERY, CC_EXPRESSION, 14'd0);
    // expression marked written through its lsb
    issue(REQ_CC, CC_EXPR_LSB, 14'd64);
    issue(REQ_QUERY, CC_VOLUME, 14'd0);
    // bend range, fine tune and coarse tune through rpn 0/x
    issue(REQ_CC, CC_RPN_MSB, 14'd0);
    issue(REQ_CC, CC_RPN_LSB, {7'd0, RPN_BEND_RANGE});
    issue(REQ_CC, CC_DATA_MSB, 14'd24);
    issue(REQ_CC, CC_DATA_LSB, 14'd127);
    issue(REQ_CC, CC_RPN_LSB, {7'd0, RPN_FINE_TUNE});
    issue(REQ_CC, CC_DATA_MSB, 14'd100);
    issue(REQ_CC, CC_RPN_LSB, {7'd0, RPN_COARSE});
    issue(REQ_CC, CC_DATA_LSB, 14'd5);
    // unknown rpn and nonzero rpn msb leave the presets alone
    issue(REQ_CC, CC_RPN_LSB, 14'd3);
    issue(REQ_CC, CC_DATA_MSB, 14'd9);
    issue(REQ_CC, CC_RPN_MSB, 14'd1);
    issue(REQ_CC, CC_DATA_MSB, 14'd1);
    // bank latch on program change with wide data
    issue(REQ_CC, CC_BANK_MSB, 14'd127);
    issue(REQ_CC, CC_BANK_LSB, 14'd127);
    issue(REQ_PC, 7'd0, 14'h3FFF);
    issue(REQ_PB, 7'd0, 14'd0);
    issue(REQ_PB, 7'd127, 14'h3FFF);
    // lsb query folds onto its msb; top controller
    issue(REQ_QUERY, CC_BANK_LSB, 14'd0);
    issue(REQ_CC, 7'd127, 14'd127);
    issue(REQ_QUERY, 7'd127, 14'd0);

    random_traffic();
    start <= 1'b0;

    // drain outstanding reports, then let any stray strobe show
    while (sb.reports_q.size() != 0) begin
      @(posedge clk);
    end
    repeat (20) @(posedge clk);
    if (sb.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
